// ----- rtl/stl_pkg.sv -----
`default_nettype none

package stl_pkg;

  // LFO phase accumulator, Q0.32
  localparam int PHASE_W = 32;
  // phase_step register width
  localparam int STEP_W = 21;
  // mod_depth register width, also the width of depth, gain and table entries
  localparam int Q15_W = 16;
  localparam logic [Q15_W-1:0] UNITY_Q15 = 16'd32768;
  localparam logic [STEP_W-1:0] STEP_RESET = 21'd894785;

  // Frame layout: left then right
  localparam int CHAN_COUNT = 2;
  localparam int CHAN_LEFT = 0;
  localparam int CHAN_RIGHT = 1;

  // Configuration channel
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 21;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH = 2'd1;

  // Table generation constants (Q2.30)
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Phase store control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } phase_ctrl_t;

  // Divide a Taylor term by (2n)(2n+1)
  function automatic logic [63:0] div_term(input logic [63:0] t, input int n);
    case (n)
      1: return t / 64'd6;
      2: return t / 64'd20;
      3: return t / 64'd42;
      4: return t / 64'd72;
      5: return t / 64'd110;
      6: return t / 64'd156;
      7: return t / 64'd210;
      8: return t / 64'd272;
      default: return t;
    endcase
  endfunction

  // sin(2*pi*m/2^bits) in Q2.30 for the first quarter wave
  function automatic logic [63:0] quarter_sine(input logic [63:0] m, input int bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x = (64'd2 * PI_Q30 * m + (64'd1 << (bits - 1))) >> bits;
    x2 = (x * x) >> 30;
    term = x;
    sum = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      term = div_term(term, n);
      if ((n & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > signed'(ONE_Q30)) begin
      sum = signed'(ONE_Q30);
    end
    return unsigned'(sum);
  endfunction

  // Unipolar sine entry (1 + sin)/2 in Q1.15, mirrored from the quarter wave
  function automatic logic [Q15_W-1:0] sine_entry(input int k, input int bits);
    int quarter;
    int quad;
    int q;
    logic signed [63:0] s;
    logic [63:0] sum;
    quarter = 1 << (bits - 2);
    quad = k >> (bits - 2);
    q = k & (quarter - 1);
    if ((quad & 1) != 0) begin
      s = signed'(quarter_sine(64'(quarter - q), bits));
    end else begin
      s = signed'(quarter_sine(64'(q), bits));
    end
    if ((quad & 2) != 0) begin
      s = -s;
    end
    sum = unsigned'(signed'(ONE_Q30) + s + 64'sd32768) >> 16;
    return sum[Q15_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/stl_ifs.sv -----
`default_nettype none

// Stereo frame going into the block
interface stl_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic valid;
  logic ready;
  logic signed [SAMPLE_WIDTH-1:0] left_in;
  logic signed [SAMPLE_WIDTH-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// Gained stereo frame coming out of the block
interface stl_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic valid;
  logic ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// Register write channel
interface stl_cfg_if;
  logic valid;
  logic ready;
  logic [stl_pkg::CFG_IDX_W-1:0] index;
  logic [stl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/stereo_tremolo_lfo_unit.sv -----
`default_nettype none

// Stereo sine-LFO tremolo. Each accepted frame (left_in, right_in, signed Q1.23) is
// multiplied by gain = (1 - depth) + depth * (1 + sin(2*pi*phase)) / 2, rounded and
// saturated, and the LFO phase then advances by phase_step modulo one. Frames are
// handled one at a time: a new frame is accepted only after the previous one has left the
// last stage. The stages are the phase read, the phase write-back
// with the sine table read, the gain from depth and table entry, the sample times gain
// multiply, and rounding into the output register. A finished frame waits in the output
// register while the next frame is accepted; when a second frame finishes before the
// first is taken, it holds in the last stage and the input stays off until the output
// drains. The phase resets to zero; phase_step resets to 894785 and mod_depth to 32768
// (full depth), and a mod_depth above 32768 acts as 32768. Writes to unknown register
// indexes are dropped. Registers should be written only while no frame is in flight.
module stereo_tremolo_lfo_unit #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  stl_in_if.sink    samples,
  stl_out_if.source gained,
  stl_cfg_if.sink   cfg
);
  import stl_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + Q15_W + 1;
  localparam int RND_W = PROD_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_GAIN,
    S_MUL,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [STEP_W-1:0] phase_step;
  logic [Q15_W-1:0]  mod_depth;

  // Datapath registers
  logic signed [SAMPLE_WIDTH-1:0] x_reg [CHAN_COUNT];
  logic signed [PROD_W-1:0]       prod [CHAN_COUNT];
  logic signed [SAMPLE_WIDTH-1:0] y_reg [CHAN_COUNT];
  logic [Q15_W-1:0]               gain;
  logic                           out_valid;

  // Memory and table interfaces
  phase_ctrl_t                phase_ctrl;
  logic [PHASE_W-1:0]         phase_rd;
  logic [PHASE_W-1:0]         phase_next;
  logic [Q15_W-1:0]           tbl_rd;

  // Combinational datapath
  logic [Q15_W-1:0]               depth_eff;
  logic [Q15_W+Q15_W-1:0]         gain_sum;
  logic [Q15_W-1:0]               gain_next;
  logic signed [SAMPLE_WIDTH-1:0] y_next [CHAN_COUNT];
  logic                           accept;

  assign cfg.ready = !rst;
  assign samples.ready = (state == S_IDLE) && !rst;
  assign accept = samples.valid && samples.ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
      mod_depth <= UNITY_Q15;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PHASE_STEP: phase_step <= cfg.data[STEP_W-1:0];
        REG_MOD_DEPTH:  mod_depth <= cfg.data[Q15_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase store: read on accept, write back in the cycle after
  assign phase_ctrl.rd_en = accept;
  assign phase_ctrl.wr_en = (state == S_PHASE);
  assign phase_next = phase_rd + {{(PHASE_W-STEP_W){1'b0}}, phase_step};

  stl_phase_mem u_phase (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (phase_ctrl),
    .wr_data (phase_next),
    .rd_data (phase_rd)
  );

  stl_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (state == S_PHASE),
    .addr    (phase_rd[PHASE_W-1 -: SINE_TABLE_BITS]),
    .rd_data (tbl_rd)
  );

  // Gain from depth and table entry
  always_comb begin
    depth_eff = (mod_depth > UNITY_Q15) ? UNITY_Q15 : mod_depth;
    gain_sum = ({16'd0, UNITY_Q15 - depth_eff} << 15) + depth_eff * tbl_rd + 32'd16384;
    gain_next = gain_sum[15 +: Q15_W];
  end

  // Round to nearest (floor of half-up) and saturate each lane
  always_comb begin
    for (int c = 0; c < CHAN_COUNT; c++) begin
      logic signed [RND_W-1:0] r;
      r = (RND_W'(prod[c]) + RND_W'(16384)) >>> 15;
      if (r > RND_W'((1 << (SAMPLE_WIDTH - 1)) - 1)) begin
        y_next[c] = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end else if (r < -RND_W'(64'sd1 << (SAMPLE_WIDTH - 1))) begin
        y_next[c] = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
        y_next[c] = r[SAMPLE_WIDTH-1:0];
      end
    end
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // output drained; a refill in S_OUT sets it again below
      if (out_valid && gained.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            x_reg[CHAN_LEFT] <= samples.left_in;
            x_reg[CHAN_RIGHT] <= samples.right_in;
            state <= S_PHASE;
          end
        end
        S_PHASE: state <= S_GAIN;
        S_GAIN: begin
          gain <= gain_next;
          state <= S_MUL;
        end
        S_MUL: begin
          for (int c = 0; c < CHAN_COUNT; c++) begin
            prod[c] <= PROD_W'(x_reg[c]) * signed'({1'b0, gain});
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || gained.ready) begin
            for (int c = 0; c < CHAN_COUNT; c++) begin
              y_reg[c] <= y_next[c];
            end
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign gained.valid = out_valid;
  assign gained.left_out = y_reg[CHAN_LEFT];
  assign gained.right_out = y_reg[CHAN_RIGHT];

endmodule

`default_nettype wire

// ----- rtl/stl_phase_mem.sv -----
`default_nettype none

// Single-entry phase store, registered synchronous read.
// Reads as zero until first written after reset.
module stl_phase_mem (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire stl_pkg::phase_ctrl_t          ctrl,
  input  wire logic [stl_pkg::PHASE_W-1:0]   wr_data,
  output logic [stl_pkg::PHASE_W-1:0]        rd_data
);
  import stl_pkg::*;

  logic [PHASE_W-1:0] mem [1];
  logic               written;

  // Entry valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= 1'b0;
    end else if (ctrl.wr_en) begin
      written <= 1'b1;
    end
  end

  // Storage write
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[0] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= written ? mem[0] : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stl_sine_rom.sv -----
`default_nettype none

// Unipolar sine table, Q1.15, registered read
module stl_sine_rom #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [SINE_TABLE_BITS-1:0] addr,
  output logic [stl_pkg::Q15_W-1:0]       rd_data
);
  import stl_pkg::*;

  localparam int TBL_SIZE = 1 << SINE_TABLE_BITS;

  logic [Q15_W-1:0] rom [TBL_SIZE];

  // Entries fixed at elaboration
  for (genvar k = 0; k < TBL_SIZE; k++) begin : g_entry
    assign rom[k] = sine_entry(k, SINE_TABLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rom[addr];
    end
  end

endmodule

`default_nettype wire

// ----- dv/stereo_tremolo_lfo_unit_tb.sv -----
module stereo_tremolo_lfo_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stl_pkg::*;

  localparam int LUT_BITS = 10;
  localparam int SAMPLE_W = 24;
  localparam int LUT_QUARTER = 1 << (LUT_BITS - 2);

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [STEP_W-1:0] STEP_MAX = 21'd1789570;
  localparam logic [STEP_W-1:0] STEP_ALL_ONES = 21'h1FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  // Q2.30 constants for the sine table
  localparam logic [63:0] PI_Q2_30 = 64'd3373259426;
  localparam logic signed [63:0] ONE_Q2_30 = 64'sd1073741824;

  localparam int IDLE_LIMIT = 3000;
  localparam int PRESSURE_HOLD = 300;
  localparam int RANDOM_PHASES = 6;
  localparam int FRAMES_PER_PHASE = 190;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_frame_t;

  logic clk = 1'b0;
  logic rst;

  stl_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) samples_if ();
  stl_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) gained_if ();
  stl_cfg_if cfg_if ();

  stereo_tremolo_lfo_unit #(
    .SINE_TABLE_BITS(LUT_BITS),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .samples(samples_if),
    .gained(gained_if),
    .cfg(cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: LFO phase, register copies, unipolar sine table
  logic [15:0] half_sine_lut [1 << LUT_BITS];
  logic [PHASE_W-1:0] phase_acc;
  logic [STEP_W-1:0] step_reg;
  logic [Q15_W-1:0] depth_reg;
  stereo_frame_t expected_gained [$];

  int error_count = 0;
  int idle_cycles = 0;
  int rx_hold_req = 0;
  bit rx_stalls_on = 1'b1;
  bit tx_idle_on = 1'b1;

  // sin(2*pi*m/N) in Q2.30 over the first quarter wave, truncated Taylor series
  function automatic logic signed [63:0] sin_quarter_q30(int unsigned m);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] t;
    logic signed [63:0] acc;
    ang = (64'd2 * PI_Q2_30 * 64'(m) + (64'd1 << (LUT_BITS - 1))) >> LUT_BITS;
    ang_sq = (ang * ang) >> 30;
    t = ang;
    acc = ang;
    for (int n = 1; n <= 8; n++) begin
      t = (t * ang_sq) >> 30;
      t = t / (64'(2 * n) * 64'(2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - signed'(t);
      end else begin
        acc = acc + signed'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > ONE_Q2_30) begin
      acc = ONE_Q2_30;
    end
    return acc;
  endfunction

  // (1 + sin)/2 in Q1.15, other quadrants mirrored from the first
  function automatic void build_lut();
    int quad;
    int q;
    logic signed [63:0] s;
    logic signed [63:0] e;
    for (int k = 0; k < (1 << LUT_BITS); k++) begin
      quad = k >> (LUT_BITS - 2);
      q = k & (LUT_QUARTER - 1);
      s = (quad & 1) ? sin_quarter_q30(LUT_QUARTER - q) : sin_quarter_q30(q);
      if (quad & 2) begin
        s = -s;
      end
      e = ONE_Q2_30 + s + 64'sd32768;
      half_sine_lut[k] = 16'(e >>> 16);
    end
  endfunction

  // Sample times Q1.15 gain, round half up, floor, clamp to 24 bits
  function automatic logic signed [SAMPLE_W-1:0] apply_gain(
    logic signed [SAMPLE_W-1:0] x,
    logic [Q15_W:0] g
  );
    logic signed [63:0] xs;
    logic signed [63:0] gs;
    logic signed [63:0] p;
    xs = x;
    gs = {47'd0, g};
    p = (xs * gs + 64'sd16384) >>> 15;
    if (p > 64'sd8388607) begin
      p = 64'sd8388607;
    end
    if (p < -64'sd8388608) begin
      p = -64'sd8388608;
    end
    return p[SAMPLE_W-1:0];
  endfunction

  // Gained frame for the current phase and registers
  function automatic stereo_frame_t predict_gained(stereo_frame_t f);
    logic [Q15_W-1:0] d;
    logic [15:0] u;
    logic [Q15_W:0] g;
    stereo_frame_t y;
    d = (depth_reg > UNITY_Q15) ? UNITY_Q15 : depth_reg;
    u = half_sine_lut[phase_acc[PHASE_W-1 -: LUT_BITS]];
    g = 17'(((64'(UNITY_Q15 - d) << 15) + 64'(d) * 64'(u) + 64'd16384) >> 15);
    y.left = apply_gain(f.left, g);
    y.right = apply_gain(f.right, g);
    return y;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      return 0;
    end
    if (roll < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return '1;
      4: return 24'($urandom_range(0, 511)) - 24'd256;
      default: return 24'($urandom());
    endcase
  endfunction

  // One frame transaction; valid stays high when no gap follows
  task automatic send_frame(
    input logic signed [SAMPLE_W-1:0] l,
    input logic signed [SAMPLE_W-1:0] r,
    input int gap
  );
    stereo_frame_t f;
    f.left = l;
    f.right = r;
    @(negedge clk);
    samples_if.valid <= 1'b1;
    samples_if.left_in <= l;
    samples_if.right_in <= r;
    do @(posedge clk); while (!samples_if.ready);
    expected_gained.push_back(predict_gained(f));
    phase_acc = phase_acc + 32'(step_reg);
    if (gap > 0) begin
      @(negedge clk);
      samples_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering frames and wait for every result
  task automatic drain_frames();
    @(negedge clk);
    samples_if.valid <= 1'b0;
    while (expected_gained.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(
    input logic [CFG_IDX_W-1:0] idx,
    input logic [CFG_DATA_W-1:0] wdata
  );
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= wdata;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_PHASE_STEP: step_reg = wdata[STEP_W-1:0];
      REG_MOD_DEPTH: depth_reg = wdata[Q15_W-1:0];
      default: ; // unmapped index, no effect
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Reset values of step and depth, sample extremes
  task automatic test_reset_state();
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, pick_gap());
    send_frame('0, '1, 0);
    send_frame(24'sh000001, 24'sh400000, pick_gap());
    send_frame(rand_sample(), rand_sample(), 0);
    send_frame(24'($urandom()), 24'($urandom()), 0);
  endtask

  // Depth and step extremes, clamped depth, unmapped indexes
  task automatic test_register_extremes();
    // zero depth: unity gain
    drain_frames();
    write_reg(REG_MOD_DEPTH, '0);
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 0);
    send_frame(rand_sample(), rand_sample(), 0);

    // all ones: low 16 bits kept, depth above full acts as full
    drain_frames();
    write_reg(REG_MOD_DEPTH, 21'h1FFFFF);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, 0);
    send_frame(rand_sample(), rand_sample(), 0);

    drain_frames();
    write_reg(REG_MOD_DEPTH, 21'd32769);
    send_frame(SAMPLE_MAX, SAMPLE_MAX, 0);
    drain_frames();
    write_reg(REG_MOD_DEPTH, 21'd1);
    send_frame(SAMPLE_MIN, SAMPLE_MIN, 0);

    drain_frames();
    write_reg(REG_PHASE_STEP, STEP_MAX);
    write_reg(REG_MOD_DEPTH, 21'(UNITY_Q15));
    send_frame(rand_sample(), rand_sample(), 0);
    send_frame(rand_sample(), rand_sample(), pick_gap());

    // step beyond the nominal range
    drain_frames();
    write_reg(REG_PHASE_STEP, STEP_ALL_ONES);
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 0);
    send_frame(rand_sample(), rand_sample(), 0);

    // zero step freezes the LFO
    drain_frames();
    write_reg(REG_PHASE_STEP, '0);
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 0);
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 0);

    drain_frames();
    write_reg(REG_SPARE_A, 21'($urandom()));
    write_reg(REG_SPARE_B, 21'h1FFFFF);
    send_frame(rand_sample(), rand_sample(), 0);
    send_frame(rand_sample(), rand_sample(), 0);
  endtask

  // Output held off while frames keep coming, input must stall
  task automatic test_output_backpressure();
    drain_frames();
    write_reg(REG_PHASE_STEP, STEP_MAX);
    write_reg(REG_MOD_DEPTH, 21'($urandom_range(0, 32768)));
    rx_hold_req = PRESSURE_HOLD;
    for (int i = 0; i < 40; i++) begin
      send_frame(rand_sample(), rand_sample(), 0);
    end
    drain_frames();
  endtask

  // Random frames over several register settings and idle patterns
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] step_word;
    logic [CFG_DATA_W-1:0] depth_word;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_frames();
      // mostly fast steps so the LFO covers much of its cycle
      if (ph == 4) begin
        step_word = 21'($urandom_range(0, STEP_MAX));
      end else begin
        step_word = 21'($urandom_range(21'h180000, STEP_ALL_ONES));
      end
      case (ph % 4)
        0: depth_word = 21'($urandom_range(0, 32768));
        1: depth_word = 21'(UNITY_Q15);
        2: depth_word = {5'($urandom()), 16'($urandom_range(32769, 65535))};
        default: depth_word = 21'($urandom());
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(REG_PHASE_STEP, step_word);
        write_reg(REG_MOD_DEPTH, depth_word);
      end else begin
        write_reg(REG_MOD_DEPTH, depth_word);
        write_reg(REG_PHASE_STEP, step_word);
      end
      tx_idle_on = (ph != 1) && (ph != 5);
      rx_stalls_on = (ph != 2) && (ph != 5);
      for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
        send_frame(rand_sample(), rand_sample(), tx_idle_on ? pick_gap() : 0);
      end
    end
    tx_idle_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Output ready: random stalls, plus a long hold on request
  initial begin : gained_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        gained_if.ready <= 1'b0;
      end else if (rx_hold_req > 0) begin
        gained_if.ready <= 1'b0;
        repeat (rx_hold_req - 1) @(negedge clk);
        rx_hold_req = 0;
      end else if (stall_left > 0) begin
        gained_if.ready <= 1'b0;
        stall_left--;
      end else begin
        gained_if.ready <= 1'b1;
        if (rx_stalls_on) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Compare each output transaction with the oldest expected frame
  always @(posedge clk) begin : check_gained
    stereo_frame_t want;
    if (!rst && gained_if.valid && gained_if.ready) begin
      if (expected_gained.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("%0t: unexpected output frame left %0d right %0d", $time,
                   $signed(gained_if.left_out), $signed(gained_if.right_out));
        end
      end else begin
        want = expected_gained.pop_front();
        if (gained_if.left_out !== want.left || gained_if.right_out !== want.right) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: frame mismatch: left exp %0d got %0d, right exp %0d got %0d",
                     $time, $signed(want.left), $signed(gained_if.left_out),
                     $signed(want.right), $signed(gained_if.right_out));
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((samples_if.valid && samples_if.ready) || (gained_if.valid && gained_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("stereo_tremolo_lfo_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    samples_if.valid = 1'b0;
    samples_if.left_in = '0;
    samples_if.right_in = '0;
    gained_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_PHASE_STEP;
    cfg_if.data = '0;
    phase_acc = '0;
    step_reg = STEP_RESET;
    depth_reg = UNITY_Q15;
    build_lut();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();

    drain_frames();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("stereo_tremolo_lfo_unit_tb: done, clean");
    end else begin
      $display("stereo_tremolo_lfo_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
